>>> hw/rtl/nws_pkg.sv
// ----------------------------------------------------------------------------
// nws_pkg
// types and codes shared by the nearest waypoint search block
// ----------------------------------------------------------------------------
package nws_pkg;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SET   = 3'd1;
  localparam logic [2:0] OP_REM   = 3'd2;
  localparam logic [2:0] OP_NEAR  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic [15:0]        wp_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        result_id;
    logic signed [15:0] result_x;
    logic signed [15:0] result_y;
    logic signed [15:0] result_z;
  } out_item_t;

endpackage

>>> hw/rtl/nearest_waypoint_search.sv
// items are handled one at a time: the back end takes the next item only
// once the previous result has been taken, and the table scan reads one
// entry a cycle
// a two-entry queue takes items while the scan runs
// reset empties the table and the queue
// ----------------------------------------------------------------------------
// nearest_waypoint_search
// keyed waypoint table with nearest point query
// ----------------------------------------------------------------------------
module nearest_waypoint_search #(
  parameter int TABLE_ENTRIES = 64,
  parameter int COORD_BITS    = 16,
  parameter int KEY_BITS      = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  nws_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output nws_pkg::out_item_t out_item
);
  import nws_pkg::*;

  logic     q_valid, q_take, q_is_near;
  in_item_t q_item;

  nws_front #(.DEPTH(2)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .q_valid, .q_take, .q_item, .q_is_near
  );

  nws_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .COORD_BITS(COORD_BITS), .KEY_BITS(KEY_BITS)
  ) u_back (
    .clk, .rst, .q_valid, .q_take, .q_item, .q_is_near,
    .out_valid, .out_stall, .out_item
  );
endmodule

>>> hw/rtl/nws_front.sv
// ----------------------------------------------------------------------------
// nws_front
// accepts items, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module nws_front #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  nws_pkg::in_item_t in_item,
  output logic              q_valid,
  input  logic              q_take,
  output nws_pkg::in_item_t q_item,
  output logic              q_is_near
);
  import nws_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  in_item_t    mem [DEPTH];
  logic        near_flag [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;
  logic          push, pop;

  assign in_stall  = (count == (AW+1)'(DEPTH));
  assign push      = in_valid && !in_stall;
  assign q_valid   = (count != '0);
  assign pop       = q_take && q_valid;
  assign q_item    = mem[rp];
  assign q_is_near = near_flag[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp]       <= in_item;
      near_flag[wp] <= (in_item.operation == OP_NEAR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

>>> hw/rtl/nws_back.sv
// ----------------------------------------------------------------------------
// nws_back
// scans the table one entry a cycle and writes the result register
// ----------------------------------------------------------------------------
module nws_back #(
  parameter int TABLE_ENTRIES = 64,
  parameter int COORD_BITS    = 16,
  parameter int KEY_BITS      = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_take,
  input  nws_pkg::in_item_t  q_item,
  input  logic               q_is_near,
  output logic               out_valid,
  input  logic               out_stall,
  output nws_pkg::out_item_t out_item
);
  import nws_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int DW = 2*(COORD_BITS+1) + 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [KEY_BITS-1:0]          mkey [TABLE_ENTRIES];
  logic signed [COORD_BITS-1:0] mx [TABLE_ENTRIES];
  logic signed [COORD_BITS-1:0] my [TABLE_ENTRIES];
  logic signed [COORD_BITS-1:0] mz [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]     valid;

  logic [1:0]  state;
  logic [IW:0] idx;
  logic        near;
  logic [2:0]  op;
  logic [KEY_BITS-1:0] key;
  logic signed [COORD_BITS-1:0] px, py, pz;

  // registered read of the current entry
  logic [KEY_BITS-1:0]          rkey;
  logic signed [COORD_BITS-1:0] rx, ry, rz;
  logic                         rvalid, rlive;
  logic [IW-1:0]                ridx;

  // squared differences, registered before the sum
  logic [DW-1:0] sqx, sqy, sqz;
  logic          sq_live, sq_ok;
  logic [KEY_BITS-1:0] sq_key;
  logic signed [COORD_BITS-1:0] sq_x, sq_y, sq_z;

  logic          have, found, have_free;
  logic [DW-1:0] best;
  logic [KEY_BITS-1:0] best_key;
  logic signed [COORD_BITS-1:0] best_x, best_y, best_z;
  logic [IW-1:0] hit_idx, free_idx;

  logic signed [COORD_BITS:0] dx, dy, dz;
  logic [DW-1:0] dsum;
  logic          cand, last_read, wr_en, clr_en;
  logic [IW-1:0] wr_idx;
  logic [1:0]    st;

  assign q_take    = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);
  assign last_read = (idx == (IW+1)'(TABLE_ENTRIES));

  always_comb begin
    dx = {rx[COORD_BITS-1], rx} - {px[COORD_BITS-1], px};
    dy = {ry[COORD_BITS-1], ry} - {py[COORD_BITS-1], py};
    dz = {rz[COORD_BITS-1], rz} - {pz[COORD_BITS-1], pz};
    dsum = sqx + sqy + sqz;
    cand = sq_ok && (!have || dsum < best || (dsum == best && sq_key < best_key));
  end

  // table memory, read one entry a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mkey[wr_idx] <= key;
      mx[wr_idx]   <= px;
      my[wr_idx]   <= py;
      mz[wr_idx]   <= pz;
    end
    rkey <= mkey[idx[IW-1:0]];
    rx   <= mx[idx[IW-1:0]];
    ry   <= my[idx[IW-1:0]];
    rz   <= mz[idx[IW-1:0]];
  end

  always_comb begin
    wr_en  = 1'b0;
    clr_en = 1'b0;
    wr_idx = hit_idx;
    st     = ST_NOT_FOUND;
    case (op)
      OP_ADD: begin
        if (found) begin
          wr_en = 1'b1; st = ST_OK;
        end else if (have_free) begin
          wr_en = 1'b1; wr_idx = free_idx; st = ST_OK;
        end else begin
          st = ST_FULL;
        end
      end
      OP_SET: begin
        wr_en = found;
        st = found ? ST_OK : ST_NOT_FOUND;
      end
      OP_REM: begin
        clr_en = found;
        st = found ? ST_OK : ST_NOT_FOUND;
      end
      OP_NEAR: st = have ? ST_OK : ST_NOT_FOUND;
      OP_READ: st = found ? ST_OK : ST_NOT_FOUND;
      default: st = ST_NOT_FOUND;
    endcase
    if (state != S_DONE) begin
      wr_en  = 1'b0;
      clr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rlive <= (state == S_SCAN) && !last_read;
    ridx  <= idx[IW-1:0];
    rvalid <= valid[idx[IW-1:0]];
    sqx <= $unsigned(DW'(dx) * DW'(dx));
    sqy <= $unsigned(DW'(dy) * DW'(dy));
    sqz <= $unsigned(DW'(dz) * DW'(dz));
    sq_live <= rlive;
    sq_ok   <= rlive && rvalid && near;
    sq_key  <= rkey;
    sq_x <= rx; sq_y <= ry; sq_z <= rz;
    if (q_take) begin
      op  <= q_item.operation;
      near <= q_is_near;
      key <= KEY_BITS'(q_item.wp_id);
      px  <= COORD_BITS'(q_item.pos_x);
      py  <= COORD_BITS'(q_item.pos_y);
      pz  <= COORD_BITS'(q_item.pos_z);
    end
    if (state == S_DONE) begin
      out_item.status <= st;
      out_item.result_id <= 16'(key);
      out_item.result_x <= '0;
      out_item.result_y <= '0;
      out_item.result_z <= '0;
      if (wr_en) begin
        out_item.result_x <= 16'(px);
        out_item.result_y <= 16'(py);
        out_item.result_z <= 16'(pz);
      end else if (op == OP_READ && found) begin
        out_item.result_x <= 16'(best_x);
        out_item.result_y <= 16'(best_y);
        out_item.result_z <= 16'(best_z);
      end else if (near) begin
        if (have) begin
          out_item.result_id <= 16'(best_key);
          out_item.result_x <= 16'(best_x);
          out_item.result_y <= 16'(best_y);
          out_item.result_z <= 16'(best_z);
        end else begin
          out_item.result_id <= '1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      idx <= '0;
      have <= 1'b0; found <= 1'b0; have_free <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_take) begin
            state <= S_SCAN;
            idx <= '0;
            have <= 1'b0; found <= 1'b0; have_free <= 1'b0;
          end
        end
        S_SCAN: begin
          if (!last_read) idx <= idx + 1'b1;
          // lookup and free slot search on the registered read
          if (rlive) begin
            if (rvalid && rkey == key && !found && !near) begin
              found <= 1'b1; hit_idx <= ridx;
              best_x <= rx; best_y <= ry; best_z <= rz;
            end
            if (!rvalid && !have_free) begin
              have_free <= 1'b1; free_idx <= ridx;
            end
          end
          if (cand) begin
            have <= 1'b1; best <= dsum; best_key <= sq_key;
            best_x <= sq_x; best_y <= sq_y; best_z <= sq_z;
          end
          if (last_read && !rlive && !sq_live) state <= S_DONE;
        end
        S_DONE: begin
          if (wr_en) valid[wr_idx] <= 1'b1;
          if (clr_en) valid[hit_idx] <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// nearest waypoint search testbench
// drives random and directed table operations through the valid/stall
// channels and checks every result against a behavioural table predictor
// ----------------------------------------------------------------------------
class waypoint_scoreboard;
  bit              slot_used[64];
  logic [15:0]     slot_key[64];
  logic signed [15:0] slot_x[64], slot_y[64], slot_z[64];
  nws_pkg::out_item_t pending[$];
  int errors;
  int results_seen;
  int full_seen;

  function int find_slot(logic [15:0] key);
    for (int i = 0; i < 64; i++)
      if (slot_used[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  function void note_item(nws_pkg::in_item_t it);
    nws_pkg::out_item_t r;
    int s;
    longint best, d, dx, dy, dz;
    r = '{status: nws_pkg::ST_NOT_FOUND, result_id: it.wp_id,
          result_x: 16'sd0, result_y: 16'sd0, result_z: 16'sd0};
    case (it.operation)
      nws_pkg::OP_ADD, nws_pkg::OP_SET: begin
        s = find_slot(it.wp_id);
        if (s < 0 && it.operation == nws_pkg::OP_ADD) begin
          for (int i = 0; i < 64; i++)
            if (!slot_used[i]) begin
              s = i;
              break;
            end
          if (s < 0) begin
            r.status = nws_pkg::ST_FULL;
            full_seen++;
          end
        end
        if (s >= 0) begin
          slot_used[s] = 1;
          slot_key[s] = it.wp_id;
          slot_x[s] = it.pos_x;
          slot_y[s] = it.pos_y;
          slot_z[s] = it.pos_z;
          r.status = nws_pkg::ST_OK;
          r.result_x = it.pos_x;
          r.result_y = it.pos_y;
          r.result_z = it.pos_z;
        end
      end
      nws_pkg::OP_REM: begin
        s = find_slot(it.wp_id);
        if (s >= 0) begin
          slot_used[s] = 0;
          r.status = nws_pkg::ST_OK;
        end
      end
      nws_pkg::OP_NEAR: begin
        s = -1;
        best = 0;
        for (int i = 0; i < 64; i++) begin
          if (!slot_used[i]) continue;
          dx = longint'(it.pos_x) - longint'(slot_x[i]);
          dy = longint'(it.pos_y) - longint'(slot_y[i]);
          dz = longint'(it.pos_z) - longint'(slot_z[i]);
          d = dx * dx + dy * dy + dz * dz;
          if (s < 0 || d < best || (d == best && slot_key[i] < slot_key[s])) begin
            s = i;
            best = d;
          end
        end
        if (s >= 0) begin
          r = '{status: nws_pkg::ST_OK, result_id: slot_key[s],
                result_x: slot_x[s], result_y: slot_y[s], result_z: slot_z[s]};
        end else begin
          r.result_id = 16'hFFFF;
        end
      end
      nws_pkg::OP_READ: begin
        s = find_slot(it.wp_id);
        if (s >= 0) begin
          r.status = nws_pkg::ST_OK;
          r.result_x = slot_x[s];
          r.result_y = slot_y[s];
          r.result_z = slot_z[s];
        end
      end
      default: ;
    endcase
    pending.insert(pending.size(), r);
  endfunction

  function void check_result(nws_pkg::out_item_t got);
    nws_pkg::out_item_t want;
    results_seen++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      errors++;
    end
    if (got.result_id !== want.result_id) begin
      $display("%0t: id expected %h actual %h", $time, want.result_id, got.result_id);
      errors++;
    end
    if (got.result_x !== want.result_x) begin
      $display("%0t: x expected %h actual %h", $time, want.result_x, got.result_x);
      errors++;
    end
    if (got.result_y !== want.result_y) begin
      $display("%0t: y expected %h actual %h", $time, want.result_y, got.result_y);
      errors++;
    end
    if (got.result_z !== want.result_z) begin
      $display("%0t: z expected %h actual %h", $time, want.result_z, got.result_z);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nws_pkg::*;

  logic clk, rst, in_valid, in_stall, out_valid, out_stall;
  in_item_t in_item;
  out_item_t out_item;
  waypoint_scoreboard board;
  in_item_t stim[$];
  bit hold_off;

  nearest_waypoint_search DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic in_item_t make_item(logic [2:0] op, logic [15:0] id,
                                         logic [15:0] x, logic [15:0] y, logic [15:0] z);
    in_item_t it;
    it.operation = op;
    it.wp_id = id;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    return it;
  endfunction

  function automatic void queue_item(in_item_t it);
    stim.insert(stim.size(), it);
  endfunction

  // keys come mostly from a small pool so that lookups hit
  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      default: return 16'($urandom_range(0, 79)) ^ 16'hA500;
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic build_stimulus();
    logic [2:0] op;
    // empty table cases, extremes, ties
    queue_item(make_item(OP_NEAR, 16'h1234, 16'd0, 16'd0, 16'd0));
    queue_item(make_item(OP_READ, 16'h0000, 16'd0, 16'd0, 16'd0));
    queue_item(make_item(OP_SET, 16'hFFFF, 16'h7FFF, 16'd0, 16'd0));
    queue_item(make_item(OP_REM, 16'h0001, 16'd0, 16'd0, 16'd0));
    queue_item(make_item(OP_ADD, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    queue_item(make_item(OP_ADD, 16'h0000, 16'h8000, 16'h8000, 16'h8000));
    queue_item(make_item(OP_NEAR, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF));
    queue_item(make_item(OP_ADD, 16'h0010, 16'd10, 16'd0, 16'd0));
    queue_item(make_item(OP_ADD, 16'h0005, -16'sd10, 16'd0, 16'd0));
    queue_item(make_item(OP_NEAR, 16'h0000, 16'd0, 16'd0, 16'd0));
    queue_item(make_item(OP_ADD, 16'h0010, 16'd20, 16'd1, 16'd2));
    queue_item(make_item(OP_SET, 16'h0010, 16'd10, 16'd0, 16'd0));
    queue_item(make_item(OP_READ, 16'h0010, 16'd0, 16'd0, 16'd0));
    queue_item(make_item(OP_REM, 16'h0005, 16'd0, 16'd0, 16'd0));
    queue_item(make_item(OP_REM, 16'h0005, 16'd0, 16'd0, 16'd0));
    queue_item(make_item(OP_READ, 16'h0005, 16'd0, 16'd0, 16'd0));
    queue_item(make_item(OP_ADD, 16'h0006, 16'd0, 16'd0, 16'd0));
    for (int o = 5; o < 8; o++)
      queue_item(make_item(3'(o), 16'h5A5A, 16'h7FFF, 16'h8000, 16'h1));
    // fill to full and six adds past it
    for (int i = 0; i < 66; i++)
      queue_item(make_item(OP_ADD, 16'h2000 + 16'(i), pick_coord(), pick_coord(),
                           pick_coord()));
    queue_item(make_item(OP_NEAR, 16'd0, 16'h8000, 16'h8000, 16'h8000));
    for (int i = 0; i < 66; i++)
      queue_item(make_item(OP_REM, 16'h2000 + 16'(i), 16'd0, 16'd0, 16'd0));
    // random mix
    for (int i = 0; i < 1600; i++) begin
      case ($urandom_range(0, 19))
        0,1,2,3,4,5: op = OP_ADD;
        6,7: op = OP_SET;
        8,9,10: op = OP_REM;
        11,12,13,14: op = OP_NEAR;
        15,16,17,18: op = OP_READ;
        default: op = 3'($urandom_range(5, 7));
      endcase
      queue_item(make_item(op, pick_key(), pick_coord(), pick_coord(), pick_coord()));
    end
  endtask

  task automatic drive_items();
    int burst, gap;
    while (stim.size() > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && stim.size() > 0) begin
        in_valid <= 1'b1;
        in_item <= stim[0];
        @(posedge clk);
        if (!in_stall) begin
          board.note_item(stim.pop_front());
          burst--;
        end
        @(negedge clk);
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
      if (gap > 0 || stim.size() == 0) in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // receiver stall pattern
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) out_stall <= 1'b1;
      else case ($urandom_range(0, 3))
        0: out_stall <= 1'b1;
        default: out_stall <= 1'b0;
      endcase
      @(negedge clk);
    end
  end

  // long hold-off so the queue fills and the input stalls
  initial begin
    hold_off = 0;
    wait (board != null && board.results_seen > 100);
    @(negedge clk);
    hold_off = 1;
    repeat (600) @(negedge clk);
    hold_off = 0;
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) board.check_result(out_item);

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    board = new();
    rst = 1;
    in_valid = 0;
    in_item = '0;
    build_stimulus();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    drive_items();
    while (board.pending.size() > 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("covered %0d results incl. %0d table-full adds, all five ops and undefined codes",
             board.results_seen, board.full_seen);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
